@@ sv/uerpm_pkg.sv @@
// Shared types, constants and codes of the ultrasonic echo ranger with PWM mapping.
package uerpm_pkg;

  localparam int MICRO_W = 17;
  localparam logic [MICRO_W-1:0] MICRO_MAX = {MICRO_W{1'b1}};

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

  localparam int DIV_W = 32;
  localparam int DIV_SW = $clog2(DIV_W);

  // Distance in centimetres is echo time / 58, taken as (echo * DIST_RECIP) >> DIST_SHIFT,
  // which is exact for every 16-bit echo time.
  localparam logic [16:0] DIST_RECIP = 17'd72316;
  localparam int DIST_SHIFT = 22;

  localparam logic [2:0] CFG_TICKS_PER_US = 3'd0;
  localparam logic [2:0] CFG_TRIGGER_US = 3'd1;
  localparam logic [2:0] CFG_TIMEOUT_US = 3'd2;
  localparam logic [2:0] CFG_HOLDOFF_US = 3'd3;
  localparam logic [2:0] CFG_PERIOD_NEAR = 3'd4;
  localparam logic [2:0] CFG_PERIOD_FAR = 3'd5;
  localparam logic [2:0] CFG_DUTY_DIVISOR = 3'd6;

  localparam logic [7:0] RST_TICKS_PER_US = 8'd48;
  localparam logic [7:0] RST_TRIGGER_US = 8'd10;
  localparam logic [15:0] RST_TIMEOUT_US = 16'd25000;
  localparam logic [16:0] RST_HOLDOFF_US = 17'd60000;
  localparam logic [15:0] RST_PERIOD_NEAR = 16'd6250;
  localparam logic [15:0] RST_PERIOD_FAR = 16'd23150;
  localparam logic [7:0] RST_DUTY_DIVISOR = 8'd5;

  typedef struct packed {
    logic [7:0]  ticks_per_us;
    logic [7:0]  trigger_us;
    logic [15:0] timeout_us;
    logic [16:0] holdoff_us;
    logic [15:0] period_near;
    logic [15:0] period_far;
    logic [7:0]  duty_divisor;
  } cfg_t;

  typedef struct packed {
    logic        trig;
    logic        done;
    logic [15:0] echo;
  } tick_rec_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [15:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [1:0] {
    PH_TRIGGER,
    PH_WAIT,
    PH_HIGH,
    PH_HOLD
  } phase_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL,
    BK_QUO_GO,
    BK_QUO,
    BK_DUTY_GO,
    BK_DUTY,
    BK_OUT
  } back_state_e;

endpackage

@@ sv/ultrasonic_echo_ranger_pwm_map_top.sv @@
// Every transfer on the input is one clock tick of the ranging loop carrying the sampled echo level,
// and every one gives exactly one result transfer. An ordinary tick passes through the tick queue
// and is then loaded into the result register, and such ticks flow at one per cycle while the
// output does not stall. A tick that completes a measurement holds the back end (one multiply,
// which also gives the distance by a reciprocal, then two passes of the shared serial divider for
// period and duty), during which the four-entry tick queue fills and the input then stalls.
// Configuration writes are accepted at any time on their own channel and take effect at once, so
// they should be made while no transfer is in flight.
module ultrasonic_echo_ranger_pwm_map_top
  import uerpm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        echo_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        trigger_out_o,
  output logic        done_res_o,
  output logic [15:0] echo_time_us_o,
  output logic        object_found_o,
  output logic [15:0] period_count_o,
  output logic [15:0] duty_count_o,
  output logic [10:0] distance_cm_o
);

  cfg_t      cfg_q;
  logic      push;
  tick_rec_t push_rec;
  logic      pop;
  tick_rec_t pop_rec;
  logic      fifo_full;
  logic      fifo_empty;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = fifo_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_us <= RST_TICKS_PER_US;
      cfg_q.trigger_us   <= RST_TRIGGER_US;
      cfg_q.timeout_us   <= RST_TIMEOUT_US;
      cfg_q.holdoff_us   <= RST_HOLDOFF_US;
      cfg_q.period_near  <= RST_PERIOD_NEAR;
      cfg_q.period_far   <= RST_PERIOD_FAR;
      cfg_q.duty_divisor <= RST_DUTY_DIVISOR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TICKS_PER_US: cfg_q.ticks_per_us <= cfg_data_i[7:0];
        CFG_TRIGGER_US:   cfg_q.trigger_us   <= cfg_data_i[7:0];
        CFG_TIMEOUT_US:   cfg_q.timeout_us   <= cfg_data_i[15:0];
        CFG_HOLDOFF_US:   cfg_q.holdoff_us   <= cfg_data_i;
        CFG_PERIOD_NEAR:  cfg_q.period_near  <= cfg_data_i[15:0];
        CFG_PERIOD_FAR:   cfg_q.period_far   <= cfg_data_i[15:0];
        CFG_DUTY_DIVISOR: cfg_q.duty_divisor <= cfg_data_i[7:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  uerpm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .echo_level_i (echo_level_i),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .rec_o        (push_rec)
  );

  uerpm_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .pop_rec_o  (pop_rec),
    .full_o     (fifo_full),
    .empty_o    (fifo_empty)
  );

  uerpm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  uerpm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .fifo_empty_i   (fifo_empty),
    .rec_i          (pop_rec),
    .pop_o          (pop),
    .div_req_o      (div_req),
    .div_rsp_i      (div_rsp),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .trigger_out_o  (trigger_out_o),
    .done_res_o     (done_res_o),
    .echo_time_us_o (echo_time_us_o),
    .object_found_o (object_found_o),
    .period_count_o (period_count_o),
    .duty_count_o   (duty_count_o),
    .distance_cm_o  (distance_cm_o)
  );

endmodule

@@ sv/uerpm_front.sv @@
// Front end: trigger, echo wait, echo width and holdoff sequencing, one tick per transfer.
module uerpm_front
  import uerpm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  input  logic      echo_level_i,
  input  logic      fifo_full_i,
  output logic      push_o,
  output tick_rec_t rec_o
);

  typedef struct packed {
    logic [7:0]         pres;
    logic [MICRO_W-1:0] micro;
  } cnt_t;

  phase_e             phase_q, phase_d;
  logic [7:0]         pres_q, pres_d;
  logic [MICRO_W-1:0] micro_q, micro_d;

  logic [7:0]  tpu;
  cnt_t        base;
  cnt_t        adv;
  logic        tmo;
  logic        trig_end;
  logic        hold_end;
  logic        done_w;
  logic [15:0] echo_w;
  logic        accept;

  function automatic cnt_t advance(input cnt_t c, input logic [7:0] t);
    cnt_t r;
    logic [8:0] p1;
    r  = c;
    p1 = {1'b0, c.pres} + 9'd1;
    if (p1 >= {1'b0, t}) begin
      r.pres = 8'd0;
      if (c.micro != MICRO_MAX) begin
        r.micro = c.micro + MICRO_W'(1);
      end
    end else begin
      r.pres = p1[7:0];
    end
    return r;
  endfunction

  assign accept = in_valid_i && !fifo_full_i;
  assign tpu = (cfg_i.ticks_per_us == 8'd0) ? 8'd1 : cfg_i.ticks_per_us;

  always_comb begin
    if (phase_q == PH_WAIT && echo_level_i) begin
      base = '0;
    end else begin
      base.pres  = pres_q;
      base.micro = micro_q;
    end
    adv = advance(base, tpu);
    tmo = (32'(adv.micro) > 32'(cfg_i.timeout_us)) || (adv.micro == MICRO_MAX);
    trig_end = (32'(adv.micro) >= 32'(cfg_i.trigger_us)) || (adv.micro == MICRO_MAX);
    hold_end = (32'(adv.micro) >= 32'(cfg_i.holdoff_us)) || (adv.micro == MICRO_MAX);
    done_w = 1'b0;
    echo_w = cfg_i.timeout_us;
    case (phase_q)
      PH_WAIT: begin
        done_w = tmo;
      end
      PH_HIGH: begin
        if (!echo_level_i) begin
          done_w = 1'b1;
          echo_w = micro_q[15:0];
        end else begin
          done_w = tmo;
        end
      end
      default: begin
        done_w = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    phase_d = phase_q;
    pres_d  = adv.pres;
    micro_d = adv.micro;
    case (phase_q)
      PH_TRIGGER: begin
        if (trig_end) begin
          phase_d = PH_WAIT;
          pres_d  = '0;
          micro_d = '0;
        end
      end
      PH_WAIT: begin
        if (done_w) begin
          phase_d = PH_HOLD;
          pres_d  = '0;
          micro_d = '0;
        end else if (echo_level_i) begin
          phase_d = PH_HIGH;
        end
      end
      PH_HIGH: begin
        if (done_w) begin
          phase_d = PH_HOLD;
          pres_d  = '0;
          micro_d = '0;
        end
      end
      PH_HOLD: begin
        if (hold_end) begin
          phase_d = PH_TRIGGER;
          pres_d  = '0;
          micro_d = '0;
        end
      end
      default: begin
        phase_d = PH_TRIGGER;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    push_o     = accept;
    rec_o.trig = (phase_q == PH_TRIGGER);
    rec_o.done = done_w;
    rec_o.echo = echo_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TRIGGER;
      pres_q  <= '0;
      micro_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      pres_q  <= pres_d;
      micro_q <= micro_d;
    end
  end

endmodule

@@ sv/uerpm_fifo.sv @@
// Short queue of tick records between the front end and the back end.
module uerpm_fifo
  import uerpm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  tick_rec_t push_rec_i,
  input  logic      pop_i,
  output tick_rec_t pop_rec_o,
  output logic      full_o,
  output logic      empty_o
);

  tick_rec_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] count_q;

  assign full_o    = (count_q == FIFO_CW'(FIFO_DEPTH));
  assign empty_o   = (count_q == '0);
  assign pop_rec_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + FIFO_CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - FIFO_CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i)) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("queue read while empty");

endmodule

@@ sv/uerpm_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
module uerpm_div
  import uerpm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic [DIV_SW-1:0] cnt_q;
  logic [DIV_W-1:0]  quo_q;
  logic [15:0]       rem_q;
  logic [15:0]       dsr_q;

  logic [16:0] shifted;
  logic        ge;
  logic [16:0] diff;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign ge      = (shifted >= {1'b0, dsr_q});
  assign diff    = shifted - {1'b0, dsr_q};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[15:0] : shifted[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_SW'(1);
        if (cnt_q == DIV_SW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/uerpm_back.sv @@
// Back end: maps finished measurements to period, duty and distance and drives the result register.
module uerpm_back
  import uerpm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        fifo_empty_i,
  input  tick_rec_t   rec_i,
  output logic        pop_o,
  output div_req_t    div_req_o,
  input  div_rsp_t    div_rsp_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        trigger_out_o,
  output logic        done_res_o,
  output logic [15:0] echo_time_us_o,
  output logic        object_found_o,
  output logic [15:0] period_count_o,
  output logic [15:0] duty_count_o,
  output logic [10:0] distance_cm_o
);

  back_state_e state_q, state_d;

  logic        out_valid_q, out_valid_d;
  logic        trig_q, done_q, found_q;
  logic [15:0] echo_q, per_q, duty_q;
  logic [10:0] dist_q;

  logic        ptrig_q;
  logic [15:0] e_q;
  logic [31:0] prod_q;
  logic        found_w_q;
  logic [15:0] per_w_q, duty_w_q;
  logic [10:0] dist_w_q;

  logic        slot_free;
  logic        load_tick;
  logic        load_meas;
  logic        upward;
  logic [15:0] span;
  logic [7:0]  dd_eff;
  logic [32:0] dist_prod;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign upward    = (cfg_i.period_far >= cfg_i.period_near);
  assign span      = upward ? (cfg_i.period_far - cfg_i.period_near)
                            : (cfg_i.period_near - cfg_i.period_far);
  assign dd_eff    = (cfg_i.duty_divisor == 8'd0) ? 8'd1 : cfg_i.duty_divisor;
  assign dist_prod = 33'(e_q) * 33'(DIST_RECIP);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!fifo_empty_i && slot_free && rec_i.done) begin
          state_d = BK_MUL;
        end
      end
      BK_MUL:     state_d = BK_QUO_GO;
      BK_QUO_GO:  state_d = BK_QUO;
      BK_QUO: begin
        if (div_rsp_i.done) begin
          state_d = BK_DUTY_GO;
        end
      end
      BK_DUTY_GO: state_d = BK_DUTY;
      BK_DUTY: begin
        if (div_rsp_i.done) begin
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (slot_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    pop_o              = 1'b0;
    load_meas          = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = prod_q;
    div_req_o.divisor  = cfg_i.timeout_us;
    case (state_q)
      BK_IDLE: begin
        pop_o = !fifo_empty_i && slot_free;
      end
      BK_QUO_GO: begin
        div_req_o.start = 1'b1;
      end
      BK_DUTY_GO: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = 32'(per_w_q);
        div_req_o.divisor  = 16'(dd_eff);
      end
      BK_OUT: begin
        load_meas = slot_free;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  assign load_tick = pop_o && !rec_i.done;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_tick || load_meas) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      e_q     <= rec_i.echo;
      ptrig_q <= rec_i.trig;
    end
    if (state_q == BK_MUL) begin
      prod_q    <= 32'(e_q) * 32'(span);
      found_w_q <= (e_q < cfg_i.timeout_us);
      dist_w_q  <= dist_prod[DIST_SHIFT+10:DIST_SHIFT];
    end
    if (state_q == BK_QUO && div_rsp_i.done) begin
      per_w_q <= upward ? (cfg_i.period_near + div_rsp_i.quotient[15:0])
                        : (cfg_i.period_near - div_rsp_i.quotient[15:0]);
    end
    if (state_q == BK_DUTY && div_rsp_i.done) begin
      duty_w_q <= div_rsp_i.quotient[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      trig_q      <= 1'b0;
      done_q      <= 1'b0;
      echo_q      <= '0;
      found_q     <= 1'b0;
      per_q       <= '0;
      duty_q      <= '0;
      dist_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (load_tick) begin
        trig_q <= rec_i.trig;
        done_q <= 1'b0;
      end else if (load_meas) begin
        trig_q  <= ptrig_q;
        done_q  <= 1'b1;
        echo_q  <= e_q;
        found_q <= found_w_q;
        per_q   <= found_w_q ? per_w_q : 16'd0;
        duty_q  <= found_w_q ? duty_w_q : 16'd0;
        dist_q  <= dist_w_q;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign trigger_out_o  = trig_q;
  assign done_res_o     = done_q;
  assign echo_time_us_o = echo_q;
  assign object_found_o = found_q;
  assign period_count_o = per_q;
  assign duty_count_o   = duty_q;
  assign distance_cm_o  = dist_q;

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> (state_q == BK_QUO || state_q == BK_DUTY))
    else $error("divider finished outside a divide step");

  a_no_object_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_q |-> (per_q == 16'd0 && duty_q == 16'd0))
    else $error("period or duty nonzero without an object");

  a_found_matches_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> (found_q == (echo_q < cfg_i.timeout_us)))
    else $error("object flag disagrees with echo time");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the echo ranger: predicts every tick result and checks it field by field.
module tb_top;
  import uerpm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int END_CYCLES = 150;
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam logic [15:0] CM_DIVISOR = 16'd58;

  typedef struct packed {
    logic        trig;
    logic        done;
    logic [15:0] echo_us;
    logic        found;
    logic [15:0] period;
    logic [15:0] duty;
    logic [10:0] dist_cm;
  } ranging_result_t;

  typedef struct packed {
    logic [2:0]  idx;
    logic [16:0] val;
  } reg_write_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        echo_level_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        trigger_out_o;
  logic        done_res_o;
  logic [15:0] echo_time_us_o;
  logic        object_found_o;
  logic [15:0] period_count_o;
  logic [15:0] duty_count_o;
  logic [10:0] distance_cm_o;

  ultrasonic_echo_ranger_pwm_map_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .echo_level_i  (echo_level_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .trigger_out_o (trigger_out_o),
    .done_res_o    (done_res_o),
    .echo_time_us_o(echo_time_us_o),
    .object_found_o(object_found_o),
    .period_count_o(period_count_o),
    .duty_count_o  (duty_count_o),
    .distance_cm_o (distance_cm_o)
  );

  always #4 clk_i = ~clk_i;

  // Predicted ranging state and register copy.
  cfg_t               ranger_regs;
  phase_e             rng_phase = PH_TRIGGER;
  logic [7:0]         pre_cnt = '0;
  logic [MICRO_W-1:0] us_cnt = '0;
  logic [15:0]        held_echo = '0;
  logic [15:0]        held_period = '0;
  logic [15:0]        held_duty = '0;
  logic               held_found = 1'b0;

  ranging_result_t pending_results[$];
  reg_write_t      reg_batch[$];
  int unsigned     ticks_sent = 0;
  int unsigned     results_seen = 0;
  int unsigned     mismatches = 0;
  int unsigned     stall_left = 0;
  bit              gaps_on = 1'b1;
  bit              stall_on = 1'b1;

  wire tick_xfer = in_valid_i & ~in_stall_o;
  wire result_xfer = out_valid_o & ~out_stall_i;
  wire cfg_xfer = cfg_valid_i & cfg_ready_o;

  function automatic void restart_count(input phase_e nxt);
    rng_phase = nxt;
    pre_cnt = '0;
    us_cnt = '0;
  endfunction

  function automatic void tick_prescaler();
    logic [8:0] nxt;
    logic [7:0] tpu;
    tpu = (ranger_regs.ticks_per_us == 8'd0) ? 8'd1 : ranger_regs.ticks_per_us;
    nxt = {1'b0, pre_cnt} + 9'd1;
    if (nxt >= {1'b0, tpu}) begin
      nxt = '0;
      if (us_cnt != MICRO_MAX) us_cnt = us_cnt + 1'b1;
    end
    pre_cnt = nxt[7:0];
  endfunction

  function automatic logic echo_wait_expired();
    return (us_cnt > {1'b0, ranger_regs.timeout_us}) || (us_cnt == MICRO_MAX);
  endfunction

  function automatic void close_measurement(input logic [15:0] width_us);
    logic [31:0] span;
    logic [31:0] per;
    logic [7:0]  dv;
    held_echo = width_us;
    if (width_us < ranger_regs.timeout_us) begin
      if (ranger_regs.period_far >= ranger_regs.period_near) begin
        span = {16'd0, ranger_regs.period_far} - {16'd0, ranger_regs.period_near};
        per = {16'd0, ranger_regs.period_near}
            + ({16'd0, width_us} * span) / {16'd0, ranger_regs.timeout_us};
      end else begin
        span = {16'd0, ranger_regs.period_near} - {16'd0, ranger_regs.period_far};
        per = {16'd0, ranger_regs.period_near}
            - ({16'd0, width_us} * span) / {16'd0, ranger_regs.timeout_us};
      end
      dv = (ranger_regs.duty_divisor == 8'd0) ? 8'd1 : ranger_regs.duty_divisor;
      held_found = 1'b1;
      held_period = per[15:0];
      held_duty = per[15:0] / {8'd0, dv};
    end else begin
      held_found = 1'b0;
      held_period = '0;
      held_duty = '0;
    end
    restart_count(PH_HOLD);
  endfunction

  function automatic ranging_result_t step_ranger(input logic echo);
    ranging_result_t r;
    r.trig = (rng_phase == PH_TRIGGER);
    r.done = 1'b0;
    case (rng_phase)
      PH_TRIGGER: begin
        tick_prescaler();
        if (us_cnt >= {9'd0, ranger_regs.trigger_us} || us_cnt == MICRO_MAX) begin
          restart_count(PH_WAIT);
        end
      end
      PH_WAIT: begin
        if (echo) restart_count(PH_HIGH);
        tick_prescaler();
        if (echo_wait_expired()) begin
          close_measurement(ranger_regs.timeout_us);
          r.done = 1'b1;
        end
      end
      PH_HIGH: begin
        if (!echo) begin
          close_measurement(us_cnt[15:0]);
          r.done = 1'b1;
        end else begin
          tick_prescaler();
          if (echo_wait_expired()) begin
            close_measurement(ranger_regs.timeout_us);
            r.done = 1'b1;
          end
        end
      end
      default: begin
        tick_prescaler();
        if (us_cnt >= ranger_regs.holdoff_us || us_cnt == MICRO_MAX) begin
          restart_count(PH_TRIGGER);
        end
      end
    endcase
    r.echo_us = held_echo;
    r.found = held_found;
    r.period = held_period;
    r.duty = held_duty;
    r.dist_cm = 11'(held_echo / CM_DIVISOR);
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("result %0d %s got %0d expected %0d", results_seen, name, got, want));
    end
  endtask

  always @(posedge clk_i) begin : check_results
    ranging_result_t want;
    if (rst_ni && result_xfer) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_results.pop_front();
        check_field("trigger_out", 16'(trigger_out_o), 16'(want.trig));
        check_field("done_res", 16'(done_res_o), 16'(want.done));
        check_field("echo_time_us", echo_time_us_o, want.echo_us);
        check_field("object_found", 16'(object_found_o), 16'(want.found));
        check_field("period_count", period_count_o, want.period);
        check_field("duty_count", duty_count_o, want.duty);
        check_field("distance_cm", 16'(distance_cm_o), 16'(want.dist_cm));
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (stall_on && $urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
    out_stall_i <= (stall_left != 0);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (tick_xfer || result_xfer || cfg_xfer) quiet = 0;
      else quiet++;
    end
    $display("tb_top failed");
    $finish;
  end

  task automatic send_tick(input logic echo);
    int unsigned gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    echo_level_i <= echo;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(step_ranger(echo));
    ticks_sent++;
  endtask

  // One well-formed ranging cycle: random echo levels until the echo is awaited, hold the echo low for
  // delay ticks, high for width ticks, then low until the measurement completes.
  task automatic range_once(input int unsigned delay, input int unsigned width);
    int unsigned n;
    while (rng_phase == PH_TRIGGER || rng_phase == PH_HOLD) send_tick(1'($urandom_range(0, 1)));
    n = 0;
    while (rng_phase == PH_WAIT && n < delay) begin
      send_tick(1'b0);
      n++;
    end
    n = 0;
    while (rng_phase != PH_HOLD && n < width) begin
      send_tick(1'b1);
      n++;
    end
    while (rng_phase != PH_HOLD) send_tick(1'b0);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic queue_write(input logic [2:0] idx, input logic [16:0] val);
    reg_batch.push_back({idx, val});
  endtask

  task automatic flush_reg_writes();
    reg_write_t w;
    while (reg_batch.size() != 0) begin
      w = reg_batch.pop_front();
      cfg_valid_i <= 1'b1;
      cfg_index_i <= w.idx;
      cfg_data_i <= w.val;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (w.idx)
        CFG_TICKS_PER_US: ranger_regs.ticks_per_us = w.val[7:0];
        CFG_TRIGGER_US: ranger_regs.trigger_us = w.val[7:0];
        CFG_TIMEOUT_US: ranger_regs.timeout_us = w.val[15:0];
        CFG_HOLDOFF_US: ranger_regs.holdoff_us = w.val;
        CFG_PERIOD_NEAR: ranger_regs.period_near = w.val[15:0];
        CFG_PERIOD_FAR: ranger_regs.period_far = w.val[15:0];
        CFG_DUTY_DIVISOR: ranger_regs.duty_divisor = w.val[7:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_state();
    repeat (4) send_tick(1'($urandom_range(0, 1)));
  endtask

  // Zero prescale, trigger, holdoff, timeout and duty divisor, with upper data bits that must be masked off.
  task automatic test_zero_registers();
    settle();
    queue_write(CFG_TICKS_PER_US, 17'h1ff00);
    queue_write(CFG_TRIGGER_US, 17'h0ab00);
    queue_write(CFG_TIMEOUT_US, 17'h10000);
    queue_write(CFG_HOLDOFF_US, 17'h00000);
    queue_write(CFG_PERIOD_NEAR, 17'h00000);
    queue_write(CFG_PERIOD_FAR, 17'h0ffff);
    queue_write(CFG_DUTY_DIVISOR, 17'h1ff00);
    queue_write(CFG_UNUSED, 17'h1ffff);
    flush_reg_writes();
    range_once(0, 1);
  endtask

  task automatic test_near_to_far();
    settle();
    queue_write(CFG_TIMEOUT_US, 17'd5);
    flush_reg_writes();
    range_once(1, 3);
  endtask

  task automatic test_far_to_near();
    settle();
    queue_write(CFG_PERIOD_NEAR, 17'h0ffff);
    queue_write(CFG_PERIOD_FAR, 17'h10000);
    queue_write(CFG_DUTY_DIVISOR, 17'h1ffff);
    queue_write(CFG_TIMEOUT_US, 17'd8);
    flush_reg_writes();
    range_once(0, 5);
  endtask

  task automatic test_echo_timeouts();
    settle();
    queue_write(CFG_TIMEOUT_US, 17'd2);
    queue_write(CFG_TRIGGER_US, 17'd1);
    flush_reg_writes();
    range_once(0, 10);
    range_once(6, 0);
  endtask

  task automatic test_random_ranging();
    int unsigned goal;
    int unsigned round_end;
    int unsigned limit;
    logic [7:0]  tpu;
    logic [7:0]  trig;
    logic [7:0]  div;
    logic [15:0] tmo;
    logic [15:0] near_p;
    logic [15:0] far_p;
    logic [16:0] hold;
    logic [16:0] noise;
    goal = ticks_sent + 550;
    while (ticks_sent < goal) begin
      settle();
      noise = 17'($urandom);
      if ($urandom_range(0, 7) == 0) tpu = 8'd0;
      else tpu = 8'($urandom_range(1, 4));
      if ($urandom_range(0, 9) == 0) tmo = 16'd0;
      else tmo = 16'($urandom_range(1, 30));
      trig = 8'($urandom_range(0, 4));
      hold = 17'($urandom_range(0, 6));
      near_p = 16'($urandom);
      far_p = 16'($urandom);
      div = 8'($urandom);
      queue_write(CFG_TICKS_PER_US, {noise[16:8], tpu});
      queue_write(CFG_TRIGGER_US, {noise[12:4], trig});
      queue_write(CFG_TIMEOUT_US, {noise[0], tmo});
      queue_write(CFG_HOLDOFF_US, hold);
      queue_write(CFG_PERIOD_NEAR, {noise[5], near_p});
      queue_write(CFG_PERIOD_FAR, {noise[11], far_p});
      queue_write(CFG_DUTY_DIVISOR, {noise[8:0], div});
      if ($urandom_range(0, 3) == 0) queue_write(CFG_UNUSED, noise);
      flush_reg_writes();
      gaps_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      limit = (tmo + 2) * ((tpu == 8'd0) ? 1 : tpu);
      round_end = ticks_sent + $urandom_range(80, 200);
      while (ticks_sent < round_end) begin
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)));
        end else begin
          range_once(($urandom_range(0, 3) == 0) ? $urandom_range(0, limit) : $urandom_range(0, 3),
                     $urandom_range(0, limit));
        end
      end
    end
  endtask

  task automatic test_register_extremes();
    // Leave any holdoff under the short settings before the longest holdoff is written.
    while (rng_phase == PH_HOLD) send_tick(1'b0);
    settle();
    gaps_on = 1'b1;
    stall_on = 1'b1;
    queue_write(CFG_TICKS_PER_US, 17'd1);
    queue_write(CFG_TRIGGER_US, 17'd255);
    queue_write(CFG_TIMEOUT_US, 17'd65535);
    queue_write(CFG_HOLDOFF_US, 17'd131071);
    queue_write(CFG_PERIOD_NEAR, 17'd0);
    queue_write(CFG_PERIOD_FAR, 17'd65535);
    queue_write(CFG_DUTY_DIVISOR, 17'd1);
    flush_reg_writes();
    range_once(2, 100);
    // The longest holdoff is cut short once the measurement is in.
    settle();
    queue_write(CFG_HOLDOFF_US, 17'd0);
    queue_write(CFG_TICKS_PER_US, 17'd255);
    queue_write(CFG_TRIGGER_US, 17'd1);
    queue_write(CFG_TIMEOUT_US, 17'd2);
    queue_write(CFG_PERIOD_NEAR, 17'd12345);
    queue_write(CFG_PERIOD_FAR, 17'd54321);
    queue_write(CFG_DUTY_DIVISOR, 17'd255);
    flush_reg_writes();
    range_once(10, 300);
  endtask

  initial begin : main
    ranger_regs.ticks_per_us = 8'd48;
    ranger_regs.trigger_us = 8'd10;
    ranger_regs.timeout_us = 16'd25000;
    ranger_regs.holdoff_us = 17'd60000;
    ranger_regs.period_near = 16'd6250;
    ranger_regs.period_far = 16'd23150;
    ranger_regs.duty_divisor = 8'd5;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_zero_registers();
    test_near_to_far();
    test_far_to_near();
    test_echo_timeouts();
    test_random_ranging();
    test_register_extremes();
    settle();
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
